// ===== rtl/core/drp_pkg.sv =====
`timescale 1ns / 1ps

package drp_pkg;

    localparam int DRP_MAX_OPTION_BYTES = 2048;

    localparam logic [7:0] OPT_PAD        = 8'h00;
    localparam logic [7:0] OPT_END        = 8'hff;
    localparam logic [7:0] OPT_RELAY      = 8'd82;
    localparam logic [7:0] SUB_CIRCUIT    = 8'd1;
    localparam logic [7:0] SUB_REMOTE     = 8'd2;
    localparam logic [7:0] CIRCUIT_LEN    = 8'd2;
    localparam logic [7:0] ADDR_LEN       = 8'd4;
    localparam logic [7:0] RELAY_BODY_LEN = 8'd10;
    localparam logic [3:0] RELAY_TOTAL    = 4'd12;
    localparam logic [3:0] APP_LAST       = 4'd12;
    localparam logic [3:0] APP_DONE       = 4'd13;
    localparam logic [3:0] BODY_ADDR_K    = 4'd6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_IFINDEX = 2'd1,
        CFG_LIMIT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_COOKIE = 3'd0,
        PH_CODE   = 3'd1,
        PH_LEN    = 3'd2,
        PH_BODY   = 3'd3,
        PH_PASS   = 3'd4,
        PH_APPEND = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        MODE_PASS   = 2'd0,
        MODE_REQ    = 2'd1,
        MODE_REPLY  = 2'd2,
        MODE_REQ_GW = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        VERDICT_UNCHANGED = 2'd0,
        VERDICT_MODIFIED  = 2'd1,
        VERDICT_DROP      = 2'd2
    } t_verdict;

    typedef struct packed {
        logic        enable;
        logic [15:0] interface_index;
        logic [10:0] option_space_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic        is_reply;
        logic [31:0] source_addr;
        logic        gateway_set;
    } t_item;

    // pre: one plain byte; app: appended bytes from app_k (to the end marker when burst)
    typedef struct packed {
        logic        pre_valid;
        logic [7:0]  pre_byte;
        logic        app_valid;
        logic [3:0]  app_k;
        logic        app_burst;
        logic        last;
        t_verdict    verdict;
        logic [31:0] addr;
        logic        found;
        logic [31:0] src;
    } t_job;

    function automatic logic [7:0] cookie_byte(input logic [1:0] i);
        logic [7:0] b;
        unique case (i)
            2'd0: b = 8'd99;
            2'd1: b = 8'd130;
            2'd2: b = 8'd83;
            default: b = 8'd99;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] app_byte(input logic [3:0] k, input logic [15:0] ifidx,
                                            input logic [31:0] src);
        logic [7:0] b;
        unique case (k)
            4'd0:  b = OPT_RELAY;
            4'd1:  b = RELAY_BODY_LEN;
            4'd2:  b = SUB_CIRCUIT;
            4'd3:  b = CIRCUIT_LEN;
            4'd4:  b = ifidx[15:8];
            4'd5:  b = ifidx[7:0];
            4'd6:  b = SUB_REMOTE;
            4'd7:  b = ADDR_LEN;
            4'd8:  b = src[31:24];
            4'd9:  b = src[23:16];
            4'd10: b = src[15:8];
            4'd11: b = src[7:0];
            default: b = OPT_END;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] expected_body(input logic [3:0] k, input logic [15:0] ifidx);
        logic [7:0] b;
        unique case (k)
            4'd0: b = SUB_CIRCUIT;
            4'd1: b = CIRCUIT_LEN;
            4'd2: b = ifidx[15:8];
            4'd3: b = ifidx[7:0];
            4'd4: b = SUB_REMOTE;
            default: b = ADDR_LEN;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/drp_if.sv =====
`timescale 1ns / 1ps

interface drp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        is_reply;
    logic [31:0] source_addr;
    logic        gateway_set;

    modport source (
        output valid, data_byte, first_byte, last_byte, is_reply, source_addr, gateway_set,
        input  ready
    );
    modport sink (
        input  valid, data_byte, first_byte, last_byte, is_reply, source_addr, gateway_set,
        output ready
    );
endinterface

interface drp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [1:0]  verdict;
    logic [31:0] dest_addr;
    logic        dest_found;

    modport source (
        output valid, out_byte, out_last, verdict, dest_addr, dest_found,
        input  ready
    );
    modport sink (
        input  valid, out_byte, out_last, verdict, dest_addr, dest_found,
        output ready
    );
endinterface

// ===== rtl/core/drp_skid.sv =====
`timescale 1ns / 1ps

module drp_skid
    import drp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    drp_in_if.sink      i_in,
    output t_item       o_item,
    output logic        o_valid,
    input  logic        i_pop
);

    logic  r_main_valid, n_main_valid;
    logic  r_spare_valid, n_spare_valid;
    t_item r_main, n_main;
    t_item r_spare, n_spare;
    t_item w_in_item;
    logic  w_accept;

    assign w_in_item = '{data_byte:   i_in.data_byte,
                         first_byte:  i_in.first_byte,
                         last_byte:   i_in.last_byte,
                         is_reply:    i_in.is_reply,
                         source_addr: i_in.source_addr,
                         gateway_set: i_in.gateway_set};

    assign i_in.ready = !r_spare_valid;
    assign w_accept   = i_in.valid && !r_spare_valid;
    assign o_item     = r_main;
    assign o_valid    = r_main_valid;

    always_comb begin
        n_main_valid  = r_main_valid;
        n_spare_valid = r_spare_valid;
        n_main        = r_main;
        n_spare       = r_spare;
        if (i_pop && r_spare_valid) begin
            n_main        = r_spare;
            n_main_valid  = 1'b1;
            n_spare_valid = 1'b0;
        end else if (i_pop || !r_main_valid) begin
            n_main       = w_in_item;
            n_main_valid = w_accept;
        end else if (w_accept) begin
            n_spare       = w_in_item;
            n_spare_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid  <= 1'b0;
            r_spare_valid <= 1'b0;
        end else begin
            r_main_valid  <= n_main_valid;
            r_spare_valid <= n_spare_valid;
        end
        r_main  <= n_main;
        r_spare <= n_spare;
    end

endmodule

// ===== rtl/core/drp_parse.sv =====
`timescale 1ns / 1ps

module drp_parse
    import drp_pkg::*;
#(
    parameter int MAX_OPTION_BYTES = DRP_MAX_OPTION_BYTES
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_item i_item,
    input  logic  i_consume,
    output t_job  o_job
);

    localparam int POS_W = $clog2(MAX_OPTION_BYTES);
    localparam int FIT_W = ((POS_W > 11) ? POS_W : 11) + 1;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_OPTION_BYTES - 1);
    localparam logic [POS_W-1:0] COOKIE_LAST = POS_W'(3);

    logic [POS_W-1:0] r_pos, n_pos, e_pos, w_pos_adv;
    t_phase           r_phase, n_phase, e_phase;
    logic [7:0]       r_obl, n_obl, e_obl;
    logic [7:0]       r_held, n_held, e_held;
    logic [3:0]       r_step, n_step, e_step;
    logic [31:0]      r_found, n_found, e_found;
    logic             r_rmo, n_rmo, e_rmo;
    logic             r_done, n_done;
    t_mode            r_mode, n_mode, e_mode;
    logic [31:0]      r_src, n_src;
    logic             r_mod, n_mod, e_mod;

    logic       w_first, w_last, w_skip, w_req, w_rr;
    logic       w_cmp_plain, w_cmp_opt, w_drop;
    logic [7:0] w_b, w_ob;
    logic [3:0] w_k;
    t_job       w_job;

    function automatic logic fits(input logic [POS_W-1:0] p, input logic [10:0] lim);
        return (FIT_W'(p) + FIT_W'(RELAY_TOTAL)) <= FIT_W'(lim);
    endfunction

    assign w_b     = i_item.data_byte;
    assign w_first = i_item.first_byte;
    assign w_last  = i_item.last_byte;
    assign o_job   = w_job;

    always_comb begin
        e_pos   = w_first ? '0 : r_pos;
        e_phase = w_first ? PH_COOKIE : r_phase;
        e_obl   = w_first ? '0 : r_obl;
        e_held  = w_first ? '0 : r_held;
        e_step  = w_first ? '0 : r_step;
        e_found = w_first ? '0 : r_found;
        e_rmo   = w_first ? 1'b0 : r_rmo;
        e_mod   = w_first ? 1'b0 : r_mod;
        n_src   = w_first ? i_item.source_addr : r_src;
        n_done  = w_first ? 1'b0 : r_done;
        if (!w_first) begin
            e_mode = r_mode;
        end else if (!i_cfg.enable) begin
            e_mode = MODE_PASS;
        end else if (i_item.is_reply) begin
            e_mode = MODE_REPLY;
        end else begin
            e_mode = i_item.gateway_set ? MODE_REQ_GW : MODE_REQ;
        end

        w_skip    = !w_first && r_done;
        w_req     = (e_mode == MODE_REQ) || (e_mode == MODE_REQ_GW);
        w_rr      = (e_held == OPT_RELAY) && (e_mode == MODE_REPLY);
        w_pos_adv = (e_pos < POS_MAX) ? e_pos + 1'b1 : e_pos;
        w_k       = 4'(RELAY_BODY_LEN - e_obl);

        n_pos   = e_pos;
        n_phase = e_phase;
        n_obl   = e_obl;
        n_held  = e_held;
        n_step  = e_step;
        n_found = e_found;
        n_rmo   = e_rmo;
        n_mod   = e_mod;
        n_mode  = e_mode;

        w_cmp_plain = 1'b0;
        w_cmp_opt   = 1'b0;
        w_drop      = 1'b0;
        w_ob        = w_b;
        w_job       = '0;

        if (!w_skip) begin
            if (e_mode == MODE_PASS || e_phase == PH_PASS) begin
                w_job.pre_valid = 1'b1;
                w_job.pre_byte  = w_b;
            end else begin
                unique case (e_phase)
                    PH_COOKIE: begin
                        w_job.pre_valid = 1'b1;
                        w_job.pre_byte  = w_b;
                        if (w_b != cookie_byte(e_pos[1:0])) begin
                            n_phase = PH_PASS;
                        end else if (e_pos >= COOKIE_LAST) begin
                            n_phase = PH_CODE;
                            n_pos   = '0;
                        end else begin
                            n_pos = e_pos + 1'b1;
                        end
                    end
                    PH_APPEND: begin
                        w_job.app_valid = 1'b1;
                        w_job.app_k     = e_step;
                        w_job.app_burst = w_last;
                        if (w_last) begin
                            n_step  = APP_DONE;
                            n_phase = PH_PASS;
                        end else begin
                            n_step = e_step + 1'b1;
                            if (e_step >= APP_LAST) begin
                                n_phase = PH_PASS;
                            end
                        end
                    end
                    PH_CODE: begin
                        if (w_b == OPT_END) begin
                            if (w_req && e_pos != '0 && fits(e_pos, i_cfg.option_space_limit))
                            begin
                                n_mod           = 1'b1;
                                w_job.app_valid = 1'b1;
                                w_job.app_k     = '0;
                                w_job.app_burst = w_last;
                                n_step          = w_last ? APP_DONE : 4'd1;
                                n_phase         = w_last ? PH_PASS : PH_APPEND;
                            end else begin
                                n_phase         = PH_PASS;
                                w_job.pre_valid = 1'b1;
                                w_job.pre_byte  = w_b;
                            end
                        end else begin
                            n_pos = w_pos_adv;
                            if (w_b == OPT_PAD) begin
                                w_cmp_plain = 1'b1;
                            end else begin
                                n_held          = w_b;
                                w_job.pre_valid = 1'b1;
                                if (w_b == OPT_RELAY && e_mode == MODE_REPLY) begin
                                    n_mod          = 1'b1;
                                    w_job.pre_byte = OPT_END;
                                end else begin
                                    w_job.pre_byte = w_b;
                                end
                                n_phase = w_last ? PH_PASS : PH_LEN;
                            end
                        end
                    end
                    PH_LEN: begin
                        n_pos = w_pos_adv;
                        n_obl = w_b;
                        if (w_rr) begin
                            n_rmo = (w_b == RELAY_BODY_LEN);
                        end
                        w_ob = w_rr ? 8'h00 : w_b;
                        if (w_b == 8'h00) begin
                            w_cmp_opt = 1'b1;
                        end else begin
                            if (w_last) begin
                                n_rmo = 1'b0;
                            end
                            w_job.pre_valid = 1'b1;
                            w_job.pre_byte  = w_ob;
                            n_phase         = w_last ? PH_PASS : PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        n_pos = w_pos_adv;
                        if (w_rr && e_rmo && e_obl != 8'h00 && e_obl <= RELAY_BODY_LEN) begin
                            if (w_k < BODY_ADDR_K) begin
                                if (w_b != expected_body(w_k, i_cfg.interface_index)) begin
                                    n_rmo = 1'b0;
                                end
                            end else begin
                                n_found = {e_found[23:0], w_b};
                            end
                        end
                        n_obl = e_obl - 1'b1;
                        w_ob  = w_rr ? 8'h00 : w_b;
                        if (n_obl == 8'h00) begin
                            w_cmp_opt = 1'b1;
                        end else begin
                            if (w_last) begin
                                n_rmo   = 1'b0;
                                n_phase = PH_PASS;
                            end
                            w_job.pre_valid = 1'b1;
                            w_job.pre_byte  = w_ob;
                        end
                    end
                    default: begin
                        w_job.pre_valid = 1'b1;
                        w_job.pre_byte  = w_b;
                    end
                endcase
            end

            if (w_cmp_opt && e_held == OPT_RELAY) begin
                if (e_mode == MODE_REQ) begin
                    w_drop          = 1'b1;
                    n_done          = 1'b1;
                    w_job.pre_valid = 1'b1;
                    w_job.pre_byte  = 8'h00;
                end else begin
                    w_job.pre_valid = 1'b1;
                    w_job.pre_byte  = w_ob;
                    n_phase         = PH_PASS;
                end
            end else if (w_cmp_opt || w_cmp_plain) begin
                n_phase         = PH_CODE;
                w_job.pre_valid = 1'b1;
                w_job.pre_byte  = w_ob;
                if (w_last && w_req && fits(n_pos, i_cfg.option_space_limit)) begin
                    n_mod           = 1'b1;
                    w_job.app_valid = 1'b1;
                    w_job.app_k     = '0;
                    w_job.app_burst = 1'b1;
                    n_step          = APP_DONE;
                    n_phase         = PH_PASS;
                end
            end

            if (w_last) begin
                n_done = 1'b1;
            end
        end

        w_job.last  = w_last || w_drop;
        w_job.src   = n_src;
        if (w_drop) begin
            w_job.verdict = VERDICT_DROP;
        end else begin
            w_job.verdict = n_mod ? VERDICT_MODIFIED : VERDICT_UNCHANGED;
        end
        w_job.found = !w_drop && n_rmo;
        w_job.addr  = w_job.found ? n_found : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_COOKIE;
            r_obl   <= '0;
            r_held  <= '0;
            r_step  <= '0;
            r_found <= '0;
            r_rmo   <= 1'b0;
            r_done  <= 1'b0;
            r_mode  <= MODE_PASS;
            r_src   <= '0;
            r_mod   <= 1'b0;
        end else if (i_consume) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_obl   <= n_obl;
            r_held  <= n_held;
            r_step  <= n_step;
            r_found <= n_found;
            r_rmo   <= n_rmo;
            r_done  <= n_done;
            r_mode  <= n_mode;
            r_src   <= n_src;
            r_mod   <= n_mod;
        end
    end

endmodule

// ===== rtl/core/drp_emit.sv =====
`timescale 1ns / 1ps

module drp_emit
    import drp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_interface_index,
    input  t_job        i_job,
    input  logic        i_load,
    output logic        o_can_take,
    drp_out_if.source   o_out
);

    logic       r_busy;
    t_job       r_job;
    logic       r_pre;
    logic [3:0] r_k;
    logic       w_final, w_fire, w_done, w_last;

    assign w_final = r_pre ? !r_job.app_valid : (!r_job.app_burst || r_k == APP_LAST);
    assign w_fire  = r_busy && o_out.ready;
    assign w_done  = w_fire && w_final;
    assign w_last  = w_final && r_job.last;

    assign o_can_take       = !r_busy || w_done;
    assign o_out.valid      = r_busy;
    assign o_out.out_byte   = r_pre ? r_job.pre_byte
                                    : app_byte(r_k, i_interface_index, r_job.src);
    assign o_out.out_last   = w_last;
    assign o_out.verdict    = w_last ? r_job.verdict : VERDICT_UNCHANGED;
    assign o_out.dest_addr  = w_last ? r_job.addr : '0;
    assign o_out.dest_found = w_last && r_job.found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
        if (i_load) begin
            r_job <= i_job;
            r_pre <= i_job.pre_valid;
            r_k   <= i_job.app_k;
        end else if (w_fire) begin
            if (r_pre) begin
                r_pre <= 1'b0;
            end else begin
                r_k <= r_k + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/dhcp_relay_option_rewriter.sv =====
`timescale 1ns / 1ps

// Relay agent information option rewriter for the DHCP option area.
// i_in carries the option area one byte per beat, magic cookie first; the
// per-packet fields (is_reply, source_addr, gateway_set) are sampled on the
// beat with first_byte set. o_out returns the rewritten area one byte per
// beat; out_last closes the packet (or carries the drop verdict) together
// with verdict, dest_addr and dest_found, which are zero on other beats.
// Configuration (enable, interface_index, option_space_limit) is written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only while
// the block is idle, which the block itself does not enforce. An accepted
// input beat passes the input skid register, then the result register.
// Throughput: one byte per cycle while o_out.ready is high; a closing byte
// that appends the relay option emits up to 14 bytes from the result
// register; two more input beats wait in the skid stage and i_in.ready drops.
// Reset (synchronous, active low) restores the register defaults, empties
// both stages and sets the parser to pass bytes unchanged until a first byte.
// When o_out.ready is low the current beat holds and input is taken until
// the skid stage fills.

module dhcp_relay_option_rewriter
    import drp_pkg::*;
#(
    parameter int MAX_OPTION_BYTES = DRP_MAX_OPTION_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    drp_in_if.sink                i_in,
    drp_out_if.source             o_out
);

    t_cfg  r_cfg;
    t_item w_item;
    logic  w_item_valid, w_can_take, w_consume, w_load;
    t_job  w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable             <= 1'b0;
            r_cfg.interface_index    <= '0;
            r_cfg.option_space_limit <= 11'd1231;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:  r_cfg.enable             <= i_cfg_data[0];
                CFG_IFINDEX: r_cfg.interface_index    <= i_cfg_data[15:0];
                CFG_LIMIT:   r_cfg.option_space_limit <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign w_consume = w_item_valid && w_can_take;
    assign w_load    = w_consume && (w_job.pre_valid || w_job.app_valid);

    drp_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_item  (w_item),
        .o_valid (w_item_valid),
        .i_pop   (w_consume)
    );

    drp_parse #(
        .MAX_OPTION_BYTES (MAX_OPTION_BYTES)
    ) u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_item    (w_item),
        .i_consume (w_consume),
        .o_job     (w_job)
    );

    drp_emit u_emit (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_interface_index (r_cfg.interface_index),
        .i_job             (w_job),
        .i_load            (w_load),
        .o_can_take        (w_can_take),
        .o_out             (o_out)
    );

`ifndef SYNTHESIS
    a_side_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.out_last) |->
            (o_out.verdict == VERDICT_UNCHANGED && !o_out.dest_found && o_out.dest_addr == '0))
        else $error("side fields set on a non-final beat");

    a_addr_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.dest_found) |-> (o_out.dest_addr == '0))
        else $error("dest_addr set without dest_found");

    a_drop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.verdict == VERDICT_DROP) |->
            (o_out.out_last && o_out.out_byte == 8'h00))
        else $error("drop verdict on a non-final beat");

    a_stall_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (w_item_valid && !w_can_take) || $past(w_item_valid && !w_can_take))
        else $error("input stalled while the parser was free");
`endif

endmodule

// ===== tb/drp_rewrite_checker.sv =====
`timescale 1ns / 1ps

module drp_rewrite_checker
    import drp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    drp_in_if                     i_in,
    drp_out_if                    i_res,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [31:0] MAGIC = {8'd99, 8'd130, 8'd83, 8'd99};

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [1:0]  verdict;
        logic [31:0] addr;
        logic        found;
    } rw_beat_t;

    rw_beat_t expected_beats[$];
    int       fails;

    // configuration copy
    logic        cfg_en;
    logic [15:0] cfg_ifidx;
    logic [10:0] cfg_limit;

    // parser copy
    logic [10:0] pos;
    t_phase      phase;
    logic [7:0]  left;
    logic [7:0]  code_b;
    logic [3:0]  app_k;
    logic [31:0] found_addr;
    logic        match_ok;
    logic        done;
    t_mode       mode;
    logic [31:0] src_r;
    logic        modified;

    assign o_fail_count = fails;

    function automatic void emit_raw(logic [7:0] b, logic lst, logic [1:0] v, logic [31:0] a,
                                     logic f);
        rw_beat_t r;
        r.data    = b;
        r.last    = lst;
        r.verdict = v;
        r.addr    = a;
        r.found   = f;
        expected_beats.push_back(r);
    endfunction

    function automatic void emit(logic [7:0] b, logic lst);
        if (lst) begin
            emit_raw(b, 1'b1, modified ? VERDICT_MODIFIED : VERDICT_UNCHANGED,
                     match_ok ? found_addr : 32'd0, match_ok);
        end else begin
            emit_raw(b, 1'b0, VERDICT_UNCHANGED, 32'd0, 1'b0);
        end
    endfunction

    function automatic void step_pos();
        if (int'(pos) < DRP_MAX_OPTION_BYTES - 1) pos = pos + 11'd1;
    endfunction

    function automatic logic room();
        return int'(pos) + int'(RELAY_TOTAL) <= int'(cfg_limit);
    endfunction

    function automatic logic is_req();
        return mode == MODE_REQ || mode == MODE_REQ_GW;
    endfunction

    function automatic logic [7:0] relay_byte(logic [3:0] k);
        logic [8*13-1:0] img;
        img = {OPT_RELAY, RELAY_BODY_LEN, SUB_CIRCUIT, CIRCUIT_LEN, cfg_ifidx,
               SUB_REMOTE, ADDR_LEN, src_r, OPT_END};
        if (k > 4'd12) return OPT_END;
        return img[8*(12-int'(k)) +: 8];
    endfunction

    function automatic logic [7:0] body_byte(logic [7:0] k);
        logic [47:0] img;
        img = {SUB_CIRCUIT, CIRCUIT_LEN, cfg_ifidx, SUB_REMOTE, ADDR_LEN};
        return img[8*(5-int'(k)) +: 8];
    endfunction

    // next appended byte, or all remaining ones when the area ends here
    function automatic void append_out(logic lst);
        logic [3:0] k;
        logic       tail;
        do begin
            k    = app_k;
            tail = (k >= RELAY_TOTAL);
            emit(relay_byte(k), lst && tail);
            app_k = k + 4'd1;
            if (tail) begin
                phase = PH_PASS;
                break;
            end
        end while (lst);
    endfunction

    function automatic void close_plain(logic [7:0] ob, logic lst);
        phase = PH_CODE;
        if (lst && is_req() && room()) begin
            emit(ob, 1'b0);
            modified = 1'b1;
            app_k    = 4'd0;
            append_out(1'b1);
        end else begin
            emit(ob, lst);
        end
    endfunction

    function automatic void close_option(logic [7:0] ob, logic lst);
        if (code_b != OPT_RELAY) begin
            close_plain(ob, lst);
            return;
        end
        if (mode == MODE_REQ) begin
            emit_raw(8'd0, 1'b1, VERDICT_DROP, 32'd0, 1'b0);
            done = 1'b1;
            return;
        end
        emit(ob, lst);
        phase = PH_PASS;
    endfunction

    function automatic void rewrite_byte(logic [7:0] b, logic lst);
        logic       rr;
        logic [7:0] ob;
        logic [7:0] kk;
        if (mode == MODE_PASS || phase == PH_PASS) begin
            emit(b, lst);
            return;
        end
        case (phase)
            PH_COOKIE: begin
                if (b != MAGIC[8*(3-int'(pos[1:0])) +: 8]) begin
                    phase = PH_PASS;
                end else if (pos >= 11'd3) begin
                    phase = PH_CODE;
                    pos   = 11'd0;
                end else begin
                    pos = pos + 11'd1;
                end
                emit(b, lst);
            end
            PH_APPEND: append_out(lst);
            PH_CODE: begin
                if (b == OPT_END) begin
                    if (is_req() && pos > 11'd0 && room()) begin
                        modified = 1'b1;
                        app_k    = 4'd0;
                        phase    = PH_APPEND;
                        append_out(lst);
                    end else begin
                        phase = PH_PASS;
                        emit(b, lst);
                    end
                end else begin
                    step_pos();
                    if (b == OPT_PAD) begin
                        close_plain(b, lst);
                    end else begin
                        code_b = b;
                        if (b == OPT_RELAY && mode == MODE_REPLY) begin
                            modified = 1'b1;
                            emit(OPT_END, lst);
                        end else begin
                            emit(b, lst);
                        end
                        phase = lst ? PH_PASS : PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                step_pos();
                rr   = code_b == OPT_RELAY && mode == MODE_REPLY;
                left = b;
                if (rr) match_ok = (b == RELAY_BODY_LEN);
                ob = rr ? 8'd0 : b;
                if (b == 8'd0) begin
                    close_option(ob, lst);
                end else begin
                    if (lst) match_ok = 1'b0;
                    emit(ob, lst);
                    phase = lst ? PH_PASS : PH_BODY;
                end
            end
            PH_BODY: begin
                step_pos();
                rr = code_b == OPT_RELAY && mode == MODE_REPLY;
                if (rr && match_ok && left >= 8'd1 && left <= RELAY_BODY_LEN) begin
                    kk = RELAY_BODY_LEN - left;
                    if (kk < 8'd6) begin
                        if (b != body_byte(kk)) match_ok = 1'b0;
                    end else begin
                        found_addr = {found_addr[23:0], b};
                    end
                end
                left = left - 8'd1;
                ob   = rr ? 8'd0 : b;
                if (left == 8'd0) begin
                    close_option(ob, lst);
                end else begin
                    if (lst) match_ok = 1'b0;
                    emit(ob, lst);
                    if (lst) phase = PH_PASS;
                end
            end
            default: emit(b, lst);
        endcase
    endfunction

    function automatic void take_beat();
        if (i_in.first_byte) begin
            pos        = 11'd0;
            phase      = PH_COOKIE;
            left       = 8'd0;
            code_b     = 8'd0;
            app_k      = 4'd0;
            found_addr = 32'd0;
            match_ok   = 1'b0;
            done       = 1'b0;
            modified   = 1'b0;
            src_r      = i_in.source_addr;
            if (!cfg_en) mode = MODE_PASS;
            else if (i_in.is_reply) mode = MODE_REPLY;
            else mode = i_in.gateway_set ? MODE_REQ_GW : MODE_REQ;
        end else if (done) begin
            return;
        end
        rewrite_byte(i_in.data_byte, i_in.last_byte);
        if (i_in.last_byte) done = 1'b1;
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            fails++;
        end
    endfunction

    function automatic void check_beat();
        rw_beat_t want;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none actual byte %02h last %0b verdict %0d",
                     $time, i_res.out_byte, i_res.out_last, i_res.verdict);
            fails++;
            return;
        end
        want = expected_beats.pop_front();
        check_field("out_byte", 32'(want.data), 32'(i_res.out_byte));
        check_field("out_last", 32'(want.last), 32'(i_res.out_last));
        check_field("verdict", 32'(want.verdict), 32'(i_res.verdict));
        check_field("dest_addr", want.addr, i_res.dest_addr);
        check_field("dest_found", 32'(want.found), 32'(i_res.dest_found));
    endfunction

    initial fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_en     = 1'b0;
            cfg_ifidx  = 16'd0;
            cfg_limit  = 11'd1231;
            pos        = 11'd0;
            phase      = PH_COOKIE;
            left       = 8'd0;
            code_b     = 8'd0;
            app_k      = 4'd0;
            found_addr = 32'd0;
            match_ok   = 1'b0;
            done       = 1'b0;
            mode       = MODE_PASS;
            src_r      = 32'd0;
            modified   = 1'b0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE:  cfg_en = i_cfg_data[0];
                    CFG_IFINDEX: cfg_ifidx = i_cfg_data[15:0];
                    CFG_LIMIT:   cfg_limit = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) take_beat();
            if (i_res.valid && i_res.ready) check_beat();
        end
        o_pending <= expected_beats.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import drp_pkg::*;

    localparam logic [31:0] MAGIC = {8'd99, 8'd130, 8'd83, 8'd99};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    drp_in_if  byte_in ();
    drp_out_if byte_out ();

    int          fail_count;
    int          pending;
    int          sent_items;
    bit          calm;
    logic [15:0] cur_ifidx;
    logic [7:0]  area[$];

    dhcp_relay_option_rewriter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (byte_in),
        .o_out      (byte_out)
    );

    drp_rewrite_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (byte_in),
        .i_res        (byte_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pause_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side backpressure
    initial begin
        int gap;
        byte_out.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            byte_out.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            gap = pause_len();
            if (gap > 0) begin
                byte_out.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic fst, input logic lst,
                             input logic rep, input logic [31:0] src, input logic gw);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            byte_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_in.valid       <= 1'b1;
        byte_in.data_byte   <= b;
        byte_in.first_byte  <= fst;
        byte_in.last_byte   <= lst;
        byte_in.is_reply    <= rep;
        byte_in.source_addr <= src;
        byte_in.gateway_set <= gw;
        @(posedge i_clk);
        while (!byte_in.ready) @(posedge i_clk);
    endtask

    task automatic settle();
        int waited;
        byte_in.valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (pending != 0 && waited < 400000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic en, input logic [15:0] idx, input logic [10:0] lim);
        write_reg(CFG_ENABLE, 16'(en));
        write_reg(CFG_IFINDEX, idx);
        write_reg(CFG_LIMIT, 16'(lim));
        cur_ifidx = idx;
    endtask

    task automatic send_area(input logic reply, input logic [31:0] src, input logic gw);
        int i;
        calm = ($urandom_range(0, 3) == 0);
        for (i = 0; i < area.size(); i++) begin
            if (i == 0) begin
                push_byte(area[i], 1'b1, area.size() == 1, reply, src, gw);
            end else begin
                push_byte(area[i], 1'b0, i == area.size() - 1, 1'($urandom), $urandom,
                          1'($urandom));
            end
        end
        sent_items += area.size();
    endtask

    task automatic put_cookie(input int n);
        int j;
        for (j = 0; j < n; j++) area.push_back(MAGIC[8*(3-j) +: 8]);
    endtask

    task automatic add_relay();
        int r, len, base;
        logic [15:0] idx;
        r = $urandom_range(0, 99);
        area.push_back(OPT_RELAY);
        if (r < 15) begin
            len = $urandom_range(0, 14);
            area.push_back(8'(len));
            repeat (len) area.push_back(8'($urandom));
            return;
        end
        idx = (r < 25) ? cur_ifidx ^ 16'($urandom_range(1, 65535)) : cur_ifidx;
        area.push_back(RELAY_BODY_LEN);
        base = area.size();
        area.push_back(SUB_CIRCUIT);
        area.push_back(CIRCUIT_LEN);
        area.push_back(idx[15:8]);
        area.push_back(idx[7:0]);
        area.push_back(SUB_REMOTE);
        area.push_back(ADDR_LEN);
        repeat (4) area.push_back(8'($urandom));
        if (r >= 25 && r < 35) area[base + $urandom_range(0, 5)] = 8'($urandom);
    endtask

    task automatic add_option(input logic reply);
        int r, len;
        logic [7:0] code;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            area.push_back(OPT_PAD);
        end else if (r < (reply ? 50 : 82)) begin
            code = 8'($urandom_range(1, 254));
            if (code == OPT_RELAY) code = code + 8'd1;
            len = $urandom_range(0, 6);
            area.push_back(code);
            area.push_back(8'(len));
            repeat (len) area.push_back(8'($urandom));
        end else if (r < 94) begin
            add_relay();
        end else begin
            area.push_back(8'($urandom));
            len = $urandom_range(0, 3);
            area.push_back(8'(len));
            repeat (len) area.push_back(8'($urandom));
        end
    endtask

    // option cut off by the end of the area
    task automatic cut_option();
        int len, keep;
        len = $urandom_range(1, 8);
        area.push_back(($urandom_range(0, 2) == 0) ? OPT_RELAY : 8'($urandom_range(1, 254)));
        keep = $urandom_range(0, len);
        if (keep > 0) begin
            area.push_back(8'(len));
            repeat (keep - 1) area.push_back(8'($urandom));
        end
    endtask

    task automatic build_area(input logic reply);
        int r, n;
        area.delete();
        r = $urandom_range(0, 99);
        if (r < 6) begin
            put_cookie($urandom_range(1, 3));
            return;
        end
        put_cookie(4);
        if (r < 12) area[$urandom_range(0, 3)] = 8'($urandom);
        n = $urandom_range(0, 4);
        repeat (n) add_option(reply);
        r = $urandom_range(0, 99);
        if (r < 65) begin
            area.push_back(OPT_END);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 2);
            repeat (n) area.push_back($urandom_range(0, 1) ? OPT_PAD : 8'($urandom));
        end else if (r >= 80 && r < 92) begin
            cut_option();
        end else if (r >= 92) begin
            repeat ($urandom_range(1, 4)) area.push_back(8'($urandom));
        end
    endtask

    task automatic random_packet();
        logic reply, gw;
        logic [31:0] src;
        int r, n;
        reply = $urandom_range(0, 99) < 45;
        gw    = $urandom_range(0, 99) < 25;
        r     = $urandom_range(0, 99);
        src   = (r < 4) ? 32'd0 : (r < 8) ? 32'hffff_ffff : $urandom;
        if ($urandom_range(0, 99) < 5) begin
            area.delete();
            repeat ($urandom_range(1, 8)) area.push_back(8'($urandom));
        end else begin
            build_area(reply);
        end
        send_area(reply, src, gw);
        // stray beats between packets
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 3);
            repeat (n) push_byte(8'($urandom), 1'b0, 1'($urandom), 1'($urandom), $urandom,
                                 1'($urandom));
        end
    endtask

    initial begin
        int ph, goal;
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_ENABLE;
        cfg_data            <= '0;
        byte_in.valid       <= 1'b0;
        byte_in.data_byte   <= 8'd0;
        byte_in.first_byte  <= 1'b0;
        byte_in.last_byte   <= 1'b0;
        byte_in.is_reply    <= 1'b0;
        byte_in.source_addr <= 32'd0;
        byte_in.gateway_set <= 1'b0;
        sent_items = 0;
        calm       = 1'b0;
        cur_ifidx  = 16'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: block disabled, byte ahead of any packet start
        push_byte(8'h5a, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0);
        area.delete();
        put_cookie(4);
        area.push_back(OPT_END);
        send_area(1'b0, $urandom, 1'b0);
        settle();

        set_config(1'b1, 16'hffff, 11'd2047);
        // leading end marker
        area.delete();
        put_cookie(4);
        area.push_back(OPT_END);
        send_area(1'b0, 32'hffff_ffff, 1'b0);
        // pad then end marker: append
        area.delete();
        put_cookie(4);
        area.push_back(OPT_PAD);
        area.push_back(OPT_END);
        send_area(1'b0, 32'd0, 1'b0);
        // relay option in a request without gateway: drop
        area.delete();
        put_cookie(4);
        area.push_back(OPT_RELAY);
        area.push_back(8'd0);
        area.push_back(OPT_PAD);
        send_area(1'b0, $urandom, 1'b0);
        // cookie mismatch
        area.delete();
        area.push_back(8'd99);
        area.push_back(8'd0);
        send_area(1'b1, $urandom, 1'b0);
        settle();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(1'b1, 16'($urandom), 11'd1231);
                1: set_config(1'b1, 16'd0, 11'd1);
                2: set_config(1'b1, 16'hffff, 11'($urandom_range(12, 48)));
                3: set_config(1'b0, 16'($urandom), 11'($urandom_range(1, 2047)));
                4: set_config(1'b1, 16'($urandom), 11'd2047);
                default: set_config(1'b1, 16'($urandom), 11'($urandom_range(20, 2047)));
            endcase
            goal = sent_items + 64;
            while (sent_items < goal) random_packet();
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== dhcp_relay_option_rewriter.f =====
rtl/core/drp_pkg.sv
rtl/core/drp_if.sv
rtl/core/drp_skid.sv
rtl/core/drp_parse.sv
rtl/core/drp_emit.sv
rtl/core/dhcp_relay_option_rewriter.sv
tb/drp_rewrite_checker.sv
tb/tb.sv
